// ----- design/spfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Shared widths, codes, controller states and the command and status words
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package spfa_pkg;

  localparam int OPCODE_W = 2;
  localparam int SIZE_W   = 11;
  localparam int OFFSET_W = 10;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int WIDE_W   = 17;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE_OFF = 2'd1,
    OP_FREE_NUM = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SLOT_SCAN,
    S_ALLOC_READ,
    S_ALLOC_CHECK,
    S_OFF_READ,
    S_OFF_CHECK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    idx_clear;
    logic    idx_inc;
    logic    take_slot;
    logic    cand_jump;
    logic    commit;
    logic    clear_idx;
    logic    clear_num;
    logic    set_result;
    status_t res_code;
    logic    res_grant;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic op_alloc;
    logic op_free_off;
    logic op_free_num;
    logic size_bad;
    logic num_in_range;
    logic slot_free;
    logic idx_last;
    logic fits;
    logic overlap;
    logic match;
    logic out_free;
  } sts_t;

endpackage

// ----- design/spfa_req_if.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator request channel
// Valid and ready handshake carrying one request word.
// ----------------------------------------------------------------------------
interface spfa_req_if;
  import spfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SIZE_W-1:0]   request_size;
  logic [OFFSET_W-1:0] start_offset;
  logic [SLOT_W-1:0]   slot_number;

  modport source (
    output valid, opcode, request_size, start_offset, slot_number,
    input  ready
  );

  modport sink (
    input  valid, opcode, request_size, start_offset, slot_number,
    output ready
  );
endinterface

// ----- design/spfa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator response channel
// Valid and ready handshake carrying one response word.
// ----------------------------------------------------------------------------
interface spfa_rsp_if;
  import spfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   granted_slot;
  logic [OFFSET_W-1:0] granted_offset;

  modport source (
    output valid, status, granted_slot, granted_offset,
    input  ready
  );

  modport sink (
    input  valid, status, granted_slot, granted_offset,
    output ready
  );
endinterface

// ----- design/slot_pool_first_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// Slot pool first-fit allocator
// One word is in flight at a time, and the next word is accepted the cycle
// after the result is loaded, so no new word is taken before the last is done.
// A free by number, a bad size or an unused opcode is settled in the decode
// state; a free by offset reads the slot table entry by entry, and an allocate
// first searches for a free slot and then scans the table for a first fit
// through its one read port. Reset clears the slot valid flags at once.
// ----------------------------------------------------------------------------
module slot_pool_first_fit_allocator #(
  parameter int SLOT_COUNT = 16,
  parameter int POOL_BYTES = 1024
) (
  input logic         clk,
  input logic         rst,
  spfa_req_if.sink    req,
  spfa_rsp_if.source  rsp
);
  import spfa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic req_ready;

  assign req.ready = req_ready;

  spfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spfa_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .POOL_BYTES (POOL_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (req.opcode),
    .request_size   (req.request_size),
    .start_offset   (req.start_offset),
    .slot_number    (req.slot_number),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .status         (rsp.status),
    .granted_slot   (rsp.granted_slot),
    .granted_offset (rsp.granted_offset)
  );

endmodule

// ----- design/spfa_dp.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator datapath
// Request registers, slot table with valid flags, scan index, candidate start
// and the output register.
// ----------------------------------------------------------------------------
module spfa_dp #(
  parameter int SLOT_COUNT = 16,
  parameter int POOL_BYTES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  spfa_pkg::cmd_t                 cmd,
  output spfa_pkg::sts_t                 sts,
  input  logic [spfa_pkg::OPCODE_W-1:0]  opcode,
  input  logic [spfa_pkg::SIZE_W-1:0]    request_size,
  input  logic [spfa_pkg::OFFSET_W-1:0]  start_offset,
  input  logic [spfa_pkg::SLOT_W-1:0]    slot_number,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [spfa_pkg::STATUS_W-1:0]  status,
  output logic [spfa_pkg::SLOT_W-1:0]    granted_slot,
  output logic [spfa_pkg::OFFSET_W-1:0]  granted_offset
);
  import spfa_pkg::*;

  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OW     = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;
  localparam int SW     = $clog2(POOL_BYTES + 1) + 1;

  logic [OPCODE_W-1:0] op;
  logic [SIZE_W-1:0]   size;
  logic [OFFSET_W-1:0] start;
  logic [SLOT_W-1:0]   number;

  logic [SIDX_W-1:0]   idx;
  logic [SIDX_W-1:0]   free_slot;
  logic [SW-1:0]       cand;

  logic [SLOT_COUNT-1:0] valid_bits;
  logic [OW-1:0]         mem_first [SLOT_COUNT];
  logic [OW-1:0]         mem_last  [SLOT_COUNT];
  logic [OW-1:0]         rd_first;
  logic [OW-1:0]         rd_last;
  logic                  rd_valid;

  status_t             res_code;
  logic [SLOT_W-1:0]   res_slot;
  logic [OFFSET_W-1:0] res_offset;

  logic [7:0]    num_wide;
  logic [SW-1:0] size_s;
  logic [SW-1:0] end_s;
  logic [SW-1:0] limit_s;

  assign num_wide = 8'(number);
  assign size_s   = SW'(size);
  assign end_s    = cand + size_s - SW'(1);
  assign limit_s  = cand + size_s;

  always_comb begin
    sts.op_alloc     = (op == OP_ALLOC);
    sts.op_free_off  = (op == OP_FREE_OFF);
    sts.op_free_num  = (op == OP_FREE_NUM);
    sts.size_bad     = (size == '0) || (WIDE_W'(size) > WIDE_W'(POOL_BYTES));
    sts.num_in_range = (num_wide < 8'(SLOT_COUNT));
    sts.slot_free    = !valid_bits[idx];
    sts.idx_last     = (idx == SIDX_W'(SLOT_COUNT - 1));
    sts.fits         = (limit_s <= SW'(POOL_BYTES));
    sts.overlap      = rd_valid && (SW'(rd_first) <= end_s) && (SW'(rd_last) >= cand);
    sts.match        = rd_valid && (WIDE_W'(rd_first) == WIDE_W'(start));
    sts.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op     <= opcode;
      size   <= request_size;
      start  <= start_offset;
      number <= slot_number;
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + SIDX_W'(1);
    end
    if (cmd.take_slot) begin
      free_slot <= idx;
      cand      <= '0;
    end else if (cmd.cand_jump) begin
      cand <= SW'(rd_last) + SW'(1);
    end
    if (cmd.set_result) begin
      res_code   <= cmd.res_code;
      res_slot   <= cmd.res_grant ? SLOT_W'(free_slot) : '0;
      res_offset <= cmd.res_grant ? OFFSET_W'(cand) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else begin
      if (cmd.commit) begin
        valid_bits[free_slot] <= 1'b1;
      end
      if (cmd.clear_idx) begin
        valid_bits[idx] <= 1'b0;
      end
      if (cmd.clear_num) begin
        valid_bits[num_wide[SIDX_W-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem_first[free_slot] <= OW'(cand);
      mem_last[free_slot]  <= OW'(end_s);
    end
    rd_first <= mem_first[idx];
    rd_last  <= mem_last[idx];
    rd_valid <= valid_bits[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status         <= res_code;
      granted_slot   <= res_slot;
      granted_offset <= res_offset;
    end
  end

endmodule

// ----- design/spfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator controller
// Sequences the slot search, the first-fit scan and the free operations.
// ----------------------------------------------------------------------------
module spfa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  spfa_pkg::sts_t sts,
  output spfa_pkg::cmd_t cmd
);
  import spfa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.idx_clear = 1'b1;
        priority if (sts.op_alloc && sts.size_bad) begin
          cmd.set_result = 1'b1;
          cmd.res_code   = ST_BAD_SIZE;
          state_next     = S_FINISH;
        end else if (sts.op_alloc) begin
          state_next = S_SLOT_SCAN;
        end else if (sts.op_free_off) begin
          state_next = S_OFF_READ;
        end else if (sts.op_free_num && sts.num_in_range) begin
          cmd.clear_num  = 1'b1;
          cmd.set_result = 1'b1;
          cmd.res_code   = ST_OK;
          state_next     = S_FINISH;
        end else begin
          cmd.set_result = 1'b1;
          cmd.res_code   = ST_NOT_FOUND;
          state_next     = S_FINISH;
        end
      end
      S_SLOT_SCAN: begin
        priority if (sts.slot_free) begin
          cmd.take_slot = 1'b1;
          cmd.idx_clear = 1'b1;
          state_next    = S_ALLOC_READ;
        end else if (sts.idx_last) begin
          cmd.set_result = 1'b1;
          cmd.res_code   = ST_NO_SLOT;
          state_next     = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_ALLOC_READ: begin
        if (sts.fits) begin
          state_next = S_ALLOC_CHECK;
        end else begin
          cmd.set_result = 1'b1;
          cmd.res_code   = ST_NO_SPACE;
          state_next     = S_FINISH;
        end
      end
      S_ALLOC_CHECK: begin
        priority if (sts.overlap) begin
          cmd.cand_jump = 1'b1;
          cmd.idx_clear = 1'b1;
          state_next    = S_ALLOC_READ;
        end else if (sts.idx_last) begin
          cmd.commit     = 1'b1;
          cmd.set_result = 1'b1;
          cmd.res_code   = ST_OK;
          cmd.res_grant  = 1'b1;
          state_next     = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_ALLOC_READ;
        end
      end
      S_OFF_READ: begin
        state_next = S_OFF_CHECK;
      end
      S_OFF_CHECK: begin
        priority if (sts.match) begin
          cmd.clear_idx  = 1'b1;
          cmd.set_result = 1'b1;
          cmd.res_code   = ST_OK;
          state_next     = S_FINISH;
        end else if (sts.idx_last) begin
          cmd.set_result = 1'b1;
          cmd.res_code   = ST_NOT_FOUND;
          state_next     = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_OFF_READ;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
